// ----- sv/wsdef_pkg.sv -----
// Package: shared widths, constants and opcode helpers for the WebSocket frame deframer.
package wsdef_pkg;

   localparam int DataWidth    = 8;
   localparam int KindWidth    = 3;
   localparam int OpcodeWidth  = 4;
   localparam int LenWidth     = 64;
   localparam int LimitWidth   = 32;
   localparam int KeyWidth     = 32;
   localparam int PhaseWidth   = 3;
   localparam int CountWidth   = 3;
   localparam int IndexWidth   = 2;
   localparam int CsrDataWidth = 32;
   localparam int CsrAddrWidth = 3;

   localparam logic [LimitWidth-1:0] MaxLenReset = 32'd65536;

   localparam logic [PhaseWidth-1:0] PhHdr1  = 3'd0;
   localparam logic [PhaseWidth-1:0] PhHdr2  = 3'd1;
   localparam logic [PhaseWidth-1:0] PhExt16 = 3'd2;
   localparam logic [PhaseWidth-1:0] PhExt64 = 3'd3;
   localparam logic [PhaseWidth-1:0] PhMask  = 3'd4;
   localparam logic [PhaseWidth-1:0] PhData  = 3'd5;

   localparam logic [6:0] LenCodeExt16 = 7'd126;
   localparam logic [6:0] LenCodeExt64 = 7'd127;

   localparam logic [CountWidth-1:0] LastExt16 = 3'd1;
   localparam logic [CountWidth-1:0] LastExt64 = 3'd7;
   localparam logic [CountWidth-1:0] LastMask  = 3'd3;

   localparam logic RegMaxLen = 1'b0;

   function automatic logic opcode_valid(input logic [OpcodeWidth-1:0] op);
      opcode_valid = op inside {[4'd0:4'd2], [4'd8:4'd10]};
   endfunction

   function automatic logic [KindWidth-1:0] kind_of(input logic [OpcodeWidth-1:0] op);
      logic [OpcodeWidth-1:0] diff;
      diff = op - 4'd5;
      if (op <= 4'd2) begin
         kind_of = op[KindWidth-1:0];
      end else begin
         kind_of = diff[KindWidth-1:0];
      end
   endfunction

endpackage

// ----- sv/websocket_frame_deframer.sv -----
// Top level: WebSocket receive-side frame deframer, one stream word per clock while req_stall is low.
// A word that yields a result has it registered; it shows at rsp_valid in the cycle after the word is accepted.
// Throughput: one word per cycle; the next word is taken while a result waits in the
// output register, and req_stall rises only when that register is full and stalled.
// Reset (synchronous): parser returns to the first header word, lock clears, limit = 65536.
module websocket_frame_deframer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [wsdef_pkg::DataWidth-1:0]        req_data_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [wsdef_pkg::DataWidth-1:0]        rsp_payload_byte,
   output logic                                   rsp_has_byte,
   output logic [wsdef_pkg::KindWidth-1:0]        rsp_frame_kind,
   output logic                                   rsp_final_fragment,
   output logic                                   rsp_end_of_frame,
   output logic                                   rsp_protocol_error,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [wsdef_pkg::CsrAddrWidth-1:0]     paddr,
   input  logic [wsdef_pkg::CsrDataWidth-1:0]     pwdata,
   output logic [wsdef_pkg::CsrDataWidth-1:0]     prdata,
   output logic                                   pready
);
   import wsdef_pkg::*;

   logic [LimitWidth-1:0]  max_len_ff, max_len_in;
   logic [PhaseWidth-1:0]  phase_ff, phase_in;
   logic [OpcodeWidth-1:0] opcode_ff, opcode_in;
   logic                   fin_ff, fin_in;
   logic                   mask_on_ff, mask_on_in;
   logic [LenWidth-1:0]    rem_ff, rem_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [KeyWidth-1:0]    key_ff, key_in;
   logic [IndexWidth-1:0]  index_ff, index_in;
   logic                   lock_ff, lock_in;

   logic                   out_valid_ff, out_valid_in;
   logic [DataWidth-1:0]   out_byte_ff, out_byte_in;
   logic                   out_has_ff, out_has_in;
   logic [KindWidth-1:0]   out_kind_ff, out_kind_in;
   logic                   out_fin_ff, out_fin_in;
   logic                   out_eof_ff, out_eof_in;
   logic                   out_err_ff, out_err_in;

   logic                   accept;
   logic                   cfg_write;
   logic                   len_done;
   logic [LenWidth-1:0]    len_new;
   logic                   len_mask;
   logic                   oversize;
   logic [DataWidth-1:0]   key_byte;
   logic [LimitWidth-1:0]  rem_dec;
   logic [6:0]             len7;

   assign req_stall = out_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == RegMaxLen);
   assign prdata    = (paddr[2] == RegMaxLen) ? max_len_ff : '0;

   assign max_len_in = cfg_write ? pwdata : max_len_ff;

   assign len7     = req_data_byte[6:0];
   assign key_byte = key_ff[{~index_ff, 3'b000} +: DataWidth];
   assign rem_dec  = (rem_ff[LimitWidth-1:0] != '0) ? rem_ff[LimitWidth-1:0] - 1'b1 : '0;
   assign oversize = (len_new[LenWidth-1:LimitWidth] != '0) ||
                     (len_new[LimitWidth-1:0] > max_len_ff);

   always_comb begin
      phase_in   = phase_ff;
      opcode_in  = opcode_ff;
      fin_in     = fin_ff;
      mask_on_in = mask_on_ff;
      rem_in     = rem_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      index_in   = index_ff;
      lock_in    = lock_ff;

      out_valid_in = out_valid_ff & rsp_stall;
      out_byte_in  = out_byte_ff;
      out_has_in   = out_has_ff;
      out_kind_in  = out_kind_ff;
      out_fin_in   = out_fin_ff;
      out_eof_in   = out_eof_ff;
      out_err_in   = out_err_ff;

      len_done = 1'b0;
      len_new  = rem_ff;
      len_mask = mask_on_ff;

      if (accept) begin
         out_valid_in = 1'b0;
      end

      if (accept && !lock_ff) begin
         case (phase_ff)
            PhHdr1: begin
               opcode_in = req_data_byte[OpcodeWidth-1:0];
               fin_in    = req_data_byte[7];
               key_in    = '0;
               index_in  = '0;
               count_in  = '0;
               rem_in    = '0;
               if (!opcode_valid(req_data_byte[OpcodeWidth-1:0])) begin
                  lock_in      = 1'b1;
                  out_valid_in = 1'b1;
                  out_byte_in  = '0;
                  out_has_in   = 1'b0;
                  out_kind_in  = '0;
                  out_fin_in   = 1'b0;
                  out_eof_in   = 1'b1;
                  out_err_in   = 1'b1;
               end else begin
                  phase_in = PhHdr2;
               end
            end
            PhHdr2: begin
               mask_on_in = req_data_byte[7];
               len_mask   = req_data_byte[7];
               count_in   = '0;
               rem_in     = '0;
               if (len7 == LenCodeExt16) begin
                  phase_in = PhExt16;
               end else if (len7 == LenCodeExt64) begin
                  phase_in = PhExt64;
               end else begin
                  len_new  = {{(LenWidth-7){1'b0}}, len7};
                  rem_in   = len_new;
                  len_done = 1'b1;
               end
            end
            PhExt16, PhExt64: begin
               len_new = {rem_ff[LenWidth-DataWidth-1:0], req_data_byte};
               rem_in  = len_new;
               if (count_ff >= ((phase_ff == PhExt16) ? LastExt16 : LastExt64)) begin
                  len_done = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            PhMask: begin
               key_in = {key_ff[KeyWidth-DataWidth-1:0], req_data_byte};
               if (count_ff >= LastMask) begin
                  count_in = '0;
                  index_in = '0;
                  if (rem_ff == '0) begin
                     phase_in     = PhHdr1;
                     out_valid_in = 1'b1;
                     out_byte_in  = '0;
                     out_has_in   = 1'b0;
                     out_kind_in  = kind_of(opcode_ff);
                     out_fin_in   = fin_ff;
                     out_eof_in   = 1'b1;
                     out_err_in   = 1'b0;
                  end else begin
                     phase_in = PhData;
                  end
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            PhData: begin
               index_in     = index_ff + 1'b1;
               rem_in       = {{(LenWidth-LimitWidth){1'b0}}, rem_dec};
               if (rem_dec == '0) begin
                  phase_in = PhHdr1;
               end
               out_valid_in = 1'b1;
               out_byte_in  = req_data_byte ^ key_byte;
               out_has_in   = 1'b1;
               out_kind_in  = kind_of(opcode_ff);
               out_fin_in   = fin_ff;
               out_eof_in   = (rem_dec == '0);
               out_err_in   = 1'b0;
            end
            default: begin
               phase_in = PhHdr1;
            end
         endcase

         if (len_done) begin
            if (oversize) begin
               lock_in      = 1'b1;
               out_valid_in = 1'b1;
               out_byte_in  = '0;
               out_has_in   = 1'b0;
               out_kind_in  = '0;
               out_fin_in   = 1'b0;
               out_eof_in   = 1'b1;
               out_err_in   = 1'b1;
            end else begin
               count_in = '0;
               if (len_mask) begin
                  phase_in = PhMask;
               end else if (len_new == '0) begin
                  phase_in     = PhHdr1;
                  out_valid_in = 1'b1;
                  out_byte_in  = '0;
                  out_has_in   = 1'b0;
                  out_kind_in  = kind_of(opcode_ff);
                  out_fin_in   = fin_ff;
                  out_eof_in   = 1'b1;
                  out_err_in   = 1'b0;
               end else begin
                  phase_in = PhData;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MaxLenReset;
         phase_ff     <= PhHdr1;
         lock_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         phase_ff     <= phase_in;
         lock_ff      <= lock_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff   <= opcode_in;
      fin_ff      <= fin_in;
      mask_on_ff  <= mask_on_in;
      rem_ff      <= rem_in;
      count_ff    <= count_in;
      key_ff      <= key_in;
      index_ff    <= index_in;
      out_byte_ff <= out_byte_in;
      out_has_ff  <= out_has_in;
      out_kind_ff <= out_kind_in;
      out_fin_ff  <= out_fin_in;
      out_eof_ff  <= out_eof_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_has_byte       = out_has_ff;
   assign rsp_frame_kind     = out_kind_ff;
   assign rsp_final_fragment = out_fin_ff;
   assign rsp_end_of_frame   = out_eof_ff;
   assign rsp_protocol_error = out_err_ff;

   a_lock_silent: assert property (@(posedge clock) disable iff (reset)
      (lock_ff && !(out_valid_ff && rsp_stall)) |=> !rsp_valid)
      else $error("result issued while locked");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_protocol_error) |-> (rsp_end_of_frame && !rsp_has_byte))
      else $error("error result without end mark or with data");

   a_event_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_byte) |-> rsp_end_of_frame)
      else $error("event result not marked end of frame");

   a_data_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PhData) |-> ((rem_ff != '0) && (rem_ff[LenWidth-1:LimitWidth] == '0)))
      else $error("payload phase with empty or oversize length");

   a_mask_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PhMask) |-> (count_ff <= LastMask))
      else $error("mask key count out of range");

endmodule

// ----- bench/websocket_frame_deframer_tb.sv -----
// Testbench: WebSocket frame deframer checked word by word against a behavioral predictor.
module websocket_frame_deframer_tb;
   import wsdef_pkg::*;

   localparam logic [OpcodeWidth-1:0] OpCont   = 4'd0;
   localparam logic [OpcodeWidth-1:0] OpText   = 4'd1;
   localparam logic [OpcodeWidth-1:0] OpBinary = 4'd2;
   localparam logic [OpcodeWidth-1:0] OpClose  = 4'd8;
   localparam logic [OpcodeWidth-1:0] OpPing   = 4'd9;
   localparam logic [OpcodeWidth-1:0] OpPong   = 4'd10;

   localparam logic [KindWidth-1:0] KindCont   = 3'd0;
   localparam logic [KindWidth-1:0] KindText   = 3'd1;
   localparam logic [KindWidth-1:0] KindBinary = 3'd2;
   localparam logic [KindWidth-1:0] KindClose  = 3'd3;
   localparam logic [KindWidth-1:0] KindPing   = 3'd4;
   localparam logic [KindWidth-1:0] KindPong   = 3'd5;

   localparam int BadOpcode = 0;
   localparam int Over7     = 1;
   localparam int Over16    = 2;
   localparam int Over64    = 3;

   localparam logic [CsrAddrWidth-1:0] LimitAddr = {RegMaxLen, 2'b00};

   typedef struct packed {
      logic [DataWidth-1:0] payload_byte;
      logic                 has_byte;
      logic [KindWidth-1:0] frame_kind;
      logic                 final_fragment;
      logic                 end_of_frame;
      logic                 protocol_error;
   } out_word_type;

   typedef struct packed {
      logic [DataWidth-1:0] data;
      logic                 typed;
      logic                 hit;
      out_word_type         word;
   } dir_row_type;

   localparam out_word_type NoWord  = '0;
   localparam out_word_type ErrWord = '{8'h00, 1'b0, KindCont, 1'b0, 1'b1, 1'b1};

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [DataWidth-1:0]    req_data_byte = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [DataWidth-1:0]    rsp_payload_byte;
   logic                    rsp_has_byte;
   logic [KindWidth-1:0]    rsp_frame_kind;
   logic                    rsp_final_fragment;
   logic                    rsp_end_of_frame;
   logic                    rsp_protocol_error;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [CsrDataWidth-1:0] pwdata = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   websocket_frame_deframer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_payload_byte(rsp_payload_byte), .rsp_has_byte(rsp_has_byte),
      .rsp_frame_kind(rsp_frame_kind), .rsp_final_fragment(rsp_final_fragment),
      .rsp_end_of_frame(rsp_end_of_frame), .rsp_protocol_error(rsp_protocol_error),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state
   logic [PhaseWidth-1:0]  pr_phase  = PhHdr1;
   logic [OpcodeWidth-1:0] pr_opcode = '0;
   logic                   pr_fin    = 1'b0;
   logic                   pr_masked = 1'b0;
   logic [LenWidth-1:0]    pr_left   = '0;
   logic [CountWidth-1:0]  pr_count  = '0;
   logic [KeyWidth-1:0]    pr_key    = '0;
   logic [IndexWidth-1:0]  pr_kidx   = '0;
   logic                   pr_locked = 1'b0;
   logic [LimitWidth-1:0]  pr_limit  = MaxLenReset;

   out_word_type pending_words[$];
   out_word_type rsp_seen;
   int           errors = 0;
   int           words_sent = 0;
   int           stall_left = 0;
   logic         calm = 1'b0;
   logic         dir_override = 1'b0;
   dir_row_type  dir_row;

   dir_row_type dir_rows [0:23] = '{
      '{8'h81, 1'b1, 1'b0, NoWord},
      '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, KindText, 1'b1, 1'b1, 1'b0}},
      '{8'h02, 1'b1, 1'b0, NoWord},
      '{8'h83, 1'b1, 1'b0, NoWord},
      '{8'hFF, 1'b1, 1'b0, NoWord},
      '{8'h00, 1'b1, 1'b0, NoWord},
      '{8'hA5, 1'b1, 1'b0, NoWord},
      '{8'h5A, 1'b1, 1'b0, NoWord},
      '{8'hFF, 1'b0, 1'b0, NoWord},
      '{8'h00, 1'b0, 1'b0, NoWord},
      '{8'h37, 1'b0, 1'b0, NoWord},
      '{8'h88, 1'b1, 1'b0, NoWord},
      '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, KindClose, 1'b1, 1'b1, 1'b0}},
      '{8'h09, 1'b1, 1'b0, NoWord},
      '{8'h80, 1'b1, 1'b0, NoWord},
      '{8'h12, 1'b1, 1'b0, NoWord},
      '{8'h34, 1'b1, 1'b0, NoWord},
      '{8'h56, 1'b1, 1'b0, NoWord},
      '{8'h78, 1'b1, 1'b1, '{8'h00, 1'b0, KindPing, 1'b0, 1'b1, 1'b0}},
      '{8'hFA, 1'b1, 1'b0, NoWord},
      '{8'h7E, 1'b1, 1'b0, NoWord},
      '{8'h00, 1'b1, 1'b0, NoWord},
      '{8'h01, 1'b1, 1'b0, NoWord},
      '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, KindPong, 1'b1, 1'b1, 1'b0}}
   };

   function automatic logic known_opcode(input logic [OpcodeWidth-1:0] op);
      return (op <= OpBinary) || (op >= OpClose && op <= OpPong);
   endfunction

   function automatic logic [KindWidth-1:0] kind_for(input logic [OpcodeWidth-1:0] op);
      case (op)
         OpText:   return KindText;
         OpBinary: return KindBinary;
         OpClose:  return KindClose;
         OpPing:   return KindPing;
         OpPong:   return KindPong;
         default:  return KindCont;
      endcase
   endfunction

   function automatic logic [OpcodeWidth-1:0] pick_opcode();
      case ($urandom_range(0, 5))
         0:       return OpCont;
         1:       return OpText;
         2:       return OpBinary;
         3:       return OpClose;
         4:       return OpPing;
         default: return OpPong;
      endcase
   endfunction

   function automatic logic [LenWidth-1:0] pick_len(input logic [LimitWidth-1:0] lim);
      logic [LenWidth-1:0] n;
      if ($urandom_range(0, 19) == 0) begin
         n = LenWidth'($urandom_range(126, 140));
      end else if ($urandom_range(0, 3) == 0) begin
         n = LenWidth'($urandom_range(13, 40));
      end else begin
         n = LenWidth'($urandom_range(0, 12));
      end
      if (n > LenWidth'(lim)) begin
         n = LenWidth'(lim);
      end
      return n;
   endfunction

   task automatic empty_event(output logic got, output out_word_type w);
      pr_phase = PhHdr1;
      got = 1'b1;
      w = '{8'h00, 1'b0, kind_for(pr_opcode), pr_fin, 1'b1, 1'b0};
   endtask

   task automatic length_known(output logic got, output out_word_type w);
      got = 1'b0;
      w = NoWord;
      if (pr_left > LenWidth'(pr_limit)) begin
         pr_locked = 1'b1;
         got = 1'b1;
         w = ErrWord;
      end else begin
         pr_count = '0;
         if (pr_masked) begin
            pr_phase = PhMask;
         end else if (pr_left == 0) begin
            empty_event(got, w);
         end else begin
            pr_phase = PhData;
         end
      end
   endtask

   task automatic deframe_byte(input logic [DataWidth-1:0] b, output logic got,
                               output out_word_type w);
      logic [DataWidth-1:0] kb;
      logic                 is_last;
      got = 1'b0;
      w = NoWord;
      if (pr_locked) begin
         return;
      end
      case (pr_phase)
         PhHdr1: begin
            pr_opcode = b[3:0];
            pr_fin = b[7];
            pr_key = '0;
            pr_kidx = '0;
            pr_count = '0;
            pr_left = '0;
            if (known_opcode(pr_opcode)) begin
               pr_phase = PhHdr2;
            end else begin
               pr_locked = 1'b1;
               got = 1'b1;
               w = ErrWord;
            end
         end
         PhHdr2: begin
            pr_masked = b[7];
            pr_left = '0;
            pr_count = '0;
            if (b[6:0] == LenCodeExt16) begin
               pr_phase = PhExt16;
            end else if (b[6:0] == LenCodeExt64) begin
               pr_phase = PhExt64;
            end else begin
               pr_left = LenWidth'(b[6:0]);
               length_known(got, w);
            end
         end
         PhExt16, PhExt64: begin
            pr_left = {pr_left[LenWidth-9:0], b};
            if (pr_count >= ((pr_phase == PhExt16) ? LastExt16 : LastExt64)) begin
               length_known(got, w);
            end else begin
               pr_count = pr_count + 1'b1;
            end
         end
         PhMask: begin
            pr_key = {pr_key[KeyWidth-9:0], b};
            if (pr_count >= LastMask) begin
               pr_count = '0;
               pr_kidx = '0;
               if (pr_left == 0) begin
                  empty_event(got, w);
               end else begin
                  pr_phase = PhData;
               end
            end else begin
               pr_count = pr_count + 1'b1;
            end
         end
         PhData: begin
            kb = pr_key[8*(3-pr_kidx) +: 8];
            pr_kidx = pr_kidx + 1'b1;
            if (pr_left != 0) begin
               pr_left = pr_left - 1'b1;
            end
            is_last = (pr_left == 0);
            if (is_last) begin
               pr_phase = PhHdr1;
            end
            got = 1'b1;
            w = '{b ^ kb, 1'b1, kind_for(pr_opcode), pr_fin, is_last, 1'b0};
         end
         default: pr_phase = PhHdr1;
      endcase
   endtask

   task automatic show_field(input string name, input logic [7:0] e, input logic [7:0] a);
      if (e !== a) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, e, a);
         errors++;
      end
   endtask

   task automatic check_word(input out_word_type e, input out_word_type a);
      show_field("payload_byte", e.payload_byte, a.payload_byte);
      show_field("has_byte", 8'(e.has_byte), 8'(a.has_byte));
      show_field("frame_kind", 8'(e.frame_kind), 8'(a.frame_kind));
      show_field("final_fragment", 8'(e.final_fragment), 8'(a.final_fragment));
      show_field("end_of_frame", 8'(e.end_of_frame), 8'(a.end_of_frame));
      show_field("protocol_error", 8'(e.protocol_error), 8'(a.protocol_error));
   endtask

   task automatic send_byte(input logic [DataWidth-1:0] b);
      int           gap;
      logic         got;
      out_word_type w;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      words_sent++;
      deframe_byte(b, got, w);
      if (dir_override && dir_row.typed) begin
         if (dir_row.hit) begin
            pending_words.push_back(dir_row.word);
         end
      end else if (got) begin
         pending_words.push_back(w);
      end
   endtask

   task automatic send_frame(input logic [OpcodeWidth-1:0] op, input logic [LenWidth-1:0] len);
      logic                masked;
      logic [KeyWidth-1:0] key;
      int                  form;
      int                  i;
      masked = 1'($urandom_range(0, 1));
      key = $urandom;
      if (len <= 125) begin
         form = $urandom_range(0, 2);
      end else if (len < 65536) begin
         form = $urandom_range(1, 2);
      end else begin
         form = 2;
      end
      send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), op});
      case (form)
         0: send_byte({masked, len[6:0]});
         1: begin
            send_byte({masked, LenCodeExt16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: begin
            send_byte({masked, LenCodeExt64});
            for (i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
         end
      endcase
      if (masked) begin
         for (i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
      end
      for (i = 0; i < int'(len); i++) send_byte(8'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LimitWidth-1:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= LimitAddr;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pr_limit = v;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== v) begin
         $display("%0t: max_payload_len readback expected %0h, got %0h", $time, v, prdata);
         errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen = {rsp_payload_byte, rsp_has_byte, rsp_frame_kind,
                        rsp_final_fragment, rsp_end_of_frame, rsp_protocol_error};
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, got %h", $time, rsp_seen);
               errors++;
            end else begin
               check_word(pending_words.pop_front(), rsp_seen);
            end
            stall_left = calm ? 0 : $urandom_range(0, 8);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int                     i;
      int                     mode;
      logic [LimitWidth-1:0]  lim;
      logic [LenWidth-1:0]    len;
      logic [OpcodeWidth-1:0] op;
      logic [15:0]            len16;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_override = 1'b1;
      for (i = 0; i < 24; i++) begin
         dir_row = dir_rows[i];
         send_byte(dir_row.data);
      end
      dir_override = 1'b0;

      drain();
      write_limit(32'hFFFF_FFFF);
      while (words_sent < 150) begin
         calm = ($urandom_range(0, 3) == 0);
         send_frame(pick_opcode(), pick_len(pr_limit));
      end

      // only empty frames pass a zero limit
      drain();
      write_limit(32'h0000_0000);
      calm = 1'b1;
      repeat (6) send_frame(pick_opcode(), '0);
      calm = 1'b0;

      drain();
      write_limit(LimitWidth'($urandom_range(1, 20)));
      while (words_sent < 250) begin
         calm = ($urandom_range(0, 3) == 0);
         len = $urandom_range(0, 1) ? LenWidth'(pr_limit) : pick_len(pr_limit);
         send_frame(pick_opcode(), len);
      end

      // change the limit between the length code and its extension
      calm = 1'b0;
      send_byte({1'b1, 3'b000, OpBinary});
      send_byte({1'b0, LenCodeExt16});
      drain();
      write_limit(LimitWidth'($urandom_range(0, 12)));
      len16 = 16'(pr_limit);
      send_byte(len16[15:8]);
      send_byte(len16[7:0]);
      for (i = 0; i < int'(len16); i++) send_byte(8'($urandom));

      drain();
      write_limit(32'd65535);
      while (words_sent < 400) begin
         calm = ($urandom_range(0, 3) == 0);
         send_frame(pick_opcode(), pick_len(pr_limit));
      end

      // raise the single protocol error, then feed bytes to the locked block
      calm = 1'b0;
      drain();
      lim = LimitWidth'($urandom_range(0, 100));
      write_limit(lim);
      mode = $urandom_range(BadOpcode, Over64);
      if (mode == BadOpcode) begin
         i = $urandom_range(0, 9);
         op = (i < 5) ? OpcodeWidth'(i + 3) : OpcodeWidth'(i + 6);
         send_byte({4'($urandom_range(0, 15)), op});
      end else begin
         send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), pick_opcode()});
         if (mode == Over7) begin
            send_byte({1'($urandom_range(0, 1)), 7'($urandom_range(int'(lim) + 1, 125))});
         end else if (mode == Over16) begin
            send_byte({1'($urandom_range(0, 1)), LenCodeExt16});
            len16 = 16'($urandom_range(int'(lim) + 1, 65535));
            send_byte(len16[15:8]);
            send_byte(len16[7:0]);
         end else begin
            send_byte({1'($urandom_range(0, 1)), LenCodeExt64});
            send_byte({1'b1, 7'($urandom_range(0, 127))});
            repeat (7) send_byte(8'($urandom));
         end
      end
      repeat (12) send_byte(8'($urandom));

      drain();
      repeat (5) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
